@@ hw/rtl/hpt_pkg.sv @@
package hpt_pkg;

    // Binary angles: a full turn is 2^ANGLE_BITS.
    localparam int ANGLE_BITS   = 16;
    localparam int FIELD_W      = 16;
    localparam int ZEN_W        = ANGLE_BITS - 1;
    localparam int FULL_TURN    = 2 ** ANGLE_BITS;
    localparam int HALF_TURN    = 2 ** (ANGLE_BITS - 1);
    localparam int BINS_DEFAULT = 256;

    localparam logic [ZEN_W-1:0] QUARTER_TURN = ZEN_W'(2 ** (ANGLE_BITS - 2));

    typedef enum logic [1:0] {
        OP_RISE  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_ARC,
        ST_RISE,
        ST_DRAIN,
        ST_QRD_I,
        ST_QRD_J,
        ST_QMUL,
        ST_QCMP,
        ST_CLR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic decode;
        logic arc_setup;
        logic rise_read;
        logic sweep_write;
        logic query_read_i;
        logic query_read_j;
        logic query_mul;
        logic query_cmp;
        logic out_load;
    } hpt_cmd_t;

    typedef struct packed {
        op_t  op;
        logic rise_ok;
        logic walk_last;
        logic rise_last;
        logic out_free;
    } hpt_status_t;

endpackage

@@ hw/rtl/hpt_ctrl.sv @@
module hpt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hpt_pkg::hpt_status_t status,
    output hpt_pkg::hpt_cmd_t    cmd
);
    import hpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_write = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                case (status.op)
                    OP_RISE:  state_next = ST_ARC;
                    OP_QUERY: state_next = ST_QRD_I;
                    OP_CLEAR: state_next = ST_CLR;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_ARC:
            begin
                cmd.arc_setup = 1'b1;
                state_next    = status.rise_ok ? ST_RISE : ST_DONE;
            end
            ST_RISE:
            begin
                cmd.rise_read = 1'b1;
                if (status.rise_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_QRD_I:
            begin
                cmd.query_read_i = 1'b1;
                state_next       = ST_QRD_J;
            end
            ST_QRD_J:
            begin
                cmd.query_read_j = 1'b1;
                state_next       = ST_QMUL;
            end
            ST_QMUL:
            begin
                cmd.query_mul = 1'b1;
                state_next    = ST_QCMP;
            end
            ST_QCMP:
            begin
                cmd.query_cmp = 1'b1;
                state_next    = ST_DONE;
            end
            ST_CLR:
            begin
                cmd.sweep_write = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A clearing sweep always starts from bin zero.
    a_sweep_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECODE && status.op == OP_CLEAR) |=> state_reg == ST_CLR)
        else $error("clear did not enter sweep");

    a_rise_has_bins: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ARC && !status.rise_ok) |=> state_reg == ST_DONE)
        else $error("empty arc walked bins");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !status.out_free) |=> state_reg == ST_DONE)
        else $error("result dropped while output full");

endmodule

@@ hw/rtl/hpt_datapath.sv @@
module hpt_datapath #(
    parameter int BINS = hpt_pkg::BINS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpt_pkg::hpt_cmd_t    cmd,
    output hpt_pkg::hpt_status_t status,
    input  logic [1:0]           s_tuser,
    input  logic [79:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);
    import hpt_pkg::*;

    localparam int ADDR_W    = $clog2(BINS);
    localparam int NEAR_W    = $clog2(BINS + 1);
    localparam int SC_W      = FIELD_W + NEAR_W;
    localparam int U_W       = FIELD_W + ADDR_W;
    localparam int HALF_BINS = BINS / 2;
    localparam int CNT_W     = $clog2(HALF_BINS + 1);
    localparam int PA_W      = ZEN_W + FIELD_W + 1;
    localparam int PB_W      = ZEN_W + FIELD_W;
    localparam int HZ_W      = 2 * FIELD_W + 1;

    // Bin profile memory, one write and one registered read per cycle.
    logic [ZEN_W-1:0]   bin_zenith_mem [BINS];
    logic [ZEN_W-1:0]   rd_data_reg;

    // Captured item
    op_t                op_reg;
    logic [FIELD_W-1:0] az_start_reg;
    logic [FIELD_W-1:0] az_end_reg;
    logic [FIELD_W-1:0] zen_reg;
    logic [FIELD_W-1:0] qaz_reg;
    logic [FIELD_W-1:0] qzen_reg;

    logic [ADDR_W-1:0]  p_reg;
    logic [ADDR_W-1:0]  q_reg;
    logic [ADDR_W-1:0]  i_reg;
    logic [ADDR_W-1:0]  j_reg;
    logic [FIELD_W-1:0] f_reg;
    logic [ZEN_W-1:0]   bi_reg;
    logic [PA_W-1:0]    prod_a_reg;
    logic [PB_W-1:0]    prod_b_reg;
    logic               below_reg;
    logic [15:0]        m_tdata_reg;

    logic [ADDR_W-1:0]  walk_addr_reg;
    logic [ADDR_W-1:0]  walk_addr_next;
    logic [CNT_W-1:0]   remain_reg;
    logic [ZEN_W-1:0]   lowest_reg;
    logic               rmw_pend_reg;
    logic [ADDR_W-1:0]  rmw_addr_reg;
    logic               m_tvalid_reg;

    logic [ADDR_W-1:0]  p_near;
    logic [ADDR_W-1:0]  q_near;
    logic [U_W-1:0]     q_scaled;
    logic [ADDR_W-1:0]  q_idx;
    logic [ADDR_W-1:0]  arc_lo;
    logic [ADDR_W-1:0]  arc_hi;
    logic [ADDR_W-1:0]  arc_diff;
    logic               arc_wraps;
    logic [ADDR_W-1:0]  arc_first;
    logic [CNT_W-1:0]   arc_count;
    logic               rise_ok;
    logic [ZEN_W-1:0]   zen_bin;
    logic [ZEN_W-1:0]   rmw_wdata;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ZEN_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [FIELD_W:0]   weight_a;
    logic [HZ_W-1:0]    horizon;
    logic [HZ_W-1:0]    point_scaled;
    logic               out_free;

    // Round an azimuth to the nearest bin; the top rounding case wraps to bin 0.
    function automatic logic [ADDR_W-1:0] nearest_bin(input logic [FIELD_W-1:0] az);
        logic [SC_W-1:0]   scaled;
        logic [NEAR_W-1:0] near;
        scaled = SC_W'(az) * SC_W'(BINS) + SC_W'(HALF_TURN);
        near   = scaled[SC_W-1 -: NEAR_W];
        if (near == NEAR_W'(BINS))
        begin
            return '0;
        end
        return near[ADDR_W-1:0];
    endfunction

    assign p_near   = nearest_bin(az_start_reg);
    assign q_near   = nearest_bin(az_end_reg);
    assign q_scaled = U_W'(qaz_reg) * U_W'(BINS);
    assign q_idx    = q_scaled[FIELD_W +: ADDR_W];

    // Shorter arc between the two bins; exactly half a turn runs upward from the low bin.
    assign arc_lo    = (p_reg < q_reg) ? p_reg : q_reg;
    assign arc_hi    = (p_reg < q_reg) ? q_reg : p_reg;
    assign arc_diff  = arc_hi - arc_lo;
    assign arc_wraps = arc_diff > ADDR_W'(HALF_BINS);
    assign arc_first = arc_wraps ? arc_hi : arc_lo;
    assign arc_count = arc_wraps ? CNT_W'((ADDR_W + 1)'(BINS) - {1'b0, arc_diff})
                                 : CNT_W'(arc_diff);
    assign rise_ok   = (zen_reg <= {1'b0, QUARTER_TURN}) && (p_reg != q_reg);

    assign zen_bin   = zen_reg[ZEN_W-1:0];
    assign rmw_wdata = (rd_data_reg < zen_bin) ? rd_data_reg : zen_bin;

    assign walk_addr_next = (walk_addr_reg == ADDR_W'(BINS - 1)) ? '0
                                                                : walk_addr_reg + 1'b1;

    assign mem_we    = cmd.sweep_write || rmw_pend_reg;
    assign mem_waddr = cmd.sweep_write ? walk_addr_reg : rmw_addr_reg;
    assign mem_wdata = cmd.sweep_write ? QUARTER_TURN : rmw_wdata;
    assign mem_re    = cmd.rise_read || cmd.query_read_i || cmd.query_read_j;
    assign mem_raddr = cmd.query_read_i ? i_reg :
                       cmd.query_read_j ? j_reg : walk_addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_zenith_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= bin_zenith_mem[mem_raddr];
        end
    end

    // Horizon weighting, exact: left weight is full turn minus fraction.
    assign weight_a     = (FIELD_W + 1)'(FULL_TURN) - {1'b0, f_reg};
    assign horizon      = HZ_W'(prod_a_reg) + HZ_W'(prod_b_reg);
    assign point_scaled = {1'b0, qzen_reg, {FIELD_W{1'b0}}};

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_addr_reg <= '0;
            remain_reg    <= '0;
            lowest_reg    <= QUARTER_TURN;
            rmw_pend_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            rmw_pend_reg <= cmd.rise_read;
            if (cmd.decode)
            begin
                walk_addr_reg <= '0;
            end
            else if (cmd.arc_setup && rise_ok)
            begin
                walk_addr_reg <= arc_first;
            end
            else if (cmd.rise_read || cmd.sweep_write)
            begin
                walk_addr_reg <= walk_addr_next;
            end

            if (cmd.arc_setup && rise_ok)
            begin
                remain_reg <= arc_count;
            end
            else if (cmd.rise_read)
            begin
                remain_reg <= remain_reg - 1'b1;
            end

            if (cmd.sweep_write)
            begin
                lowest_reg <= QUARTER_TURN;
            end
            else if (cmd.arc_setup && rise_ok && (zen_bin < lowest_reg))
            begin
                lowest_reg <= zen_bin;
            end

            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rmw_addr_reg <= walk_addr_reg;
        if (cmd.load_in)
        begin
            op_reg       <= op_t'(s_tuser);
            az_start_reg <= s_tdata[15:0];
            az_end_reg   <= s_tdata[31:16];
            zen_reg      <= s_tdata[47:32];
            qaz_reg      <= s_tdata[63:48];
            qzen_reg     <= s_tdata[79:64];
        end
        if (cmd.decode)
        begin
            p_reg <= p_near;
            q_reg <= q_near;
            i_reg <= q_idx;
            j_reg <= (q_idx == ADDR_W'(BINS - 1)) ? '0 : q_idx + 1'b1;
            f_reg <= q_scaled[FIELD_W-1:0];
        end
        if (cmd.query_read_j)
        begin
            bi_reg <= rd_data_reg;
        end
        if (cmd.query_mul)
        begin
            prod_a_reg <= PA_W'(bi_reg) * PA_W'(weight_a);
            prod_b_reg <= PB_W'(rd_data_reg) * PB_W'(f_reg);
        end
        if (cmd.query_cmp)
        begin
            below_reg <= point_scaled > horizon;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {lowest_reg, (op_reg == OP_QUERY) && below_reg};
        end
    end

    assign status.op        = op_reg;
    assign status.rise_ok   = rise_ok;
    assign status.walk_last = walk_addr_reg == ADDR_W'(BINS - 1);
    assign status.rise_last = remain_reg == CNT_W'(1);
    assign status.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_rmw_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (rmw_pend_reg && cmd.rise_read) |-> rmw_addr_reg != walk_addr_reg)
        else $error("arc walk revisited a bin");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep_write && rmw_pend_reg))
        else $error("sweep and rise write collide");

    a_lowest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lowest_reg <= QUARTER_TURN)
        else $error("running minimum above quarter turn");

    a_arc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.arc_setup && rise_ok) |=> remain_reg != '0)
        else $error("arc with no bins");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over a waiting one");

endmodule

@@ hw/rtl/horizon_profile_table.sv @@
// A query reads bins i and j, weights them, then compares; a rise sets up its arc and walks
// its bins unless the rise changes nothing; a clear sweeps every bin; other codes go straight to the result.
// One item in flight; the next can be accepted in the cycle after the result is loaded,
// and a result held for a busy output delays that loading.
// The arc walk reads one bin per cycle through the single memory read port.
// Reset: asynchronous, active low; a sweep then sets every bin to a quarter turn.
module horizon_profile_table #(
    parameter int BINS = hpt_pkg::BINS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // azimuth_start, azimuth_end, zenith, query_azimuth,
                                   // query_zenith (16 bits each, from bit 0 up)
    input  logic [1:0]  s_tuser,   // operation: 0 rise, 1 query, 2 clear
    // Result item stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // below [0], min_zenith [15:1]
);
    import hpt_pkg::*;

    // Controller and datapath meet only through these two bundles.
    hpt_cmd_t    cmd;
    hpt_status_t status;

    hpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Holds the bin memory, arc walker, interpolation multipliers and the
    // output register; a result may wait there while the next item is taken.
    hpt_datapath #(
        .BINS (BINS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
